// File: hw/rtl/bcsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsi_pkg
// Shared types and constants for the byte count to SI text formatter.
// ----------------------------------------------------------------------------
package bcsi_pkg;

  // Data widths.
  localparam int unsigned CountW   = 64;
  localparam int unsigned ResultW  = 56;
  localparam int unsigned StepBits = 8;
  localparam int unsigned StepCnt  = CountW / StepBits;
  localparam int unsigned StepCntW = $clog2(StepCnt);

  // Divisor of one scaling step.
  localparam logic [10:0] Thousand = 11'd1000;

  // ASCII codes used by the formatter.
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiDot   = 8'h2E;
  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiB     = 8'h42;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new byte count
    logic start_div;  // prepare a division by one thousand
    logic div_step;   // eight quotient bits of the division
    logic round;      // round and choose the text layout
    logic digits;     // split the integer part into decimal digits
    logic pack;       // build the characters into the output register
  } bcsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_k;    // working value is below one thousand
    logic out_free;   // output register can take a result this cycle
  } bcsi_status_t;

  // SI prefix character for a scaling level; level zero is kilo.
  function automatic logic [7:0] prefix_char(input logic [2:0] level);
    logic [7:0] c;
    c = "k";
    case (level)
      3'd0:    c = "k";
      3'd1:    c = "M";
      3'd2:    c = "G";
      3'd3:    c = "T";
      3'd4:    c = "P";
      3'd5:    c = "E";
      3'd6:    c = "Z";
      default: c = "Y";
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/bcsi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsi_ctrl
// Sequencer: scaling loop by one thousand, then rounding, digits and packing.
// ----------------------------------------------------------------------------
module bcsi_ctrl
  import bcsi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  bcsi_status_t status_i,
  output bcsi_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDiv,
    StRound,
    StDigit,
    StPack
  } state_e;

  state_e               state_q, state_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (status_i.below_k) begin
          state_d = StRound;
        end else begin
          cmd_o.start_div = 1'b1;
          cnt_d           = '0;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(StepCnt - 1)) begin
          state_d = StScan;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        state_d     = StDigit;
      end
      StDigit: begin
        cmd_o.digits = 1'b1;
        state_d      = StPack;
      end
      StPack: begin
        if (status_i.out_free) begin
          cmd_o.pack = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/bcsi_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsi_dpath
// Datapath: radix-256 long division by one thousand, rounding, decimal
// digit split and character placement into the output register.
// ----------------------------------------------------------------------------
module bcsi_dpath
  import bcsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcsi_cmd_t          cmd_i,
  output bcsi_status_t       status_o,
  input  logic [CountW-1:0]  count_i,
  input  logic               m_axis_tready,
  output logic               m_axis_tvalid,
  output logic [ResultW-1:0] m_axis_tdata
);

  // Scaling state.
  logic [CountW-1:0] work_q, work_d;
  logic [9:0]        rem_q, rem_d;
  logic              sticky_q;
  logic [2:0]        level_q;
  logic              scaled_q;

  // Layout chosen by rounding.
  logic [9:0] val_q, val_d;
  logic [3:0] frac_q, frac_d;
  logic       has_frac_q, has_frac_d;
  logic       has_pfx_q, has_pfx_d;
  logic [7:0] pfx_q, pfx_d;

  // Decimal digits of the integer part.
  logic [3:0] dig_h_q, dig_h_d;
  logic [3:0] dig_t_q, dig_t_d;
  logic [3:0] dig_o_q, dig_o_d;
  logic [1:0] ndig_q, ndig_d;

  // Output register.
  logic               out_valid_q;
  logic [ResultW-1:0] out_data_q, out_data_d;

  assign status_o.below_k  = (work_q < CountW'(Thousand));
  assign status_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid     = out_valid_q;
  assign m_axis_tdata      = out_data_q;

  // One division step: eight restoring steps bring in the top byte.
  always_comb begin
    logic [10:0] part;
    logic [7:0]  qbyte;
    part  = {1'b0, rem_q};
    qbyte = '0;
    for (int i = 0; i < StepBits; i++) begin
      part = {part[9:0], work_q[CountW-1-i]};
      if (part >= Thousand) begin
        part                    = part - Thousand;
        qbyte[StepBits-1-i]     = 1'b1;
      end
    end
    rem_d  = part[9:0];
    work_d = {work_q[CountW-StepBits-1:0], qbyte};
  end

  // Rounding: half to even, exact ties broken upward by the sticky bit.
  always_comb begin
    logic [9:0]  n;
    logic [15:0] prod_m;
    logic [3:0]  m;
    logic [9:0]  rr_w;
    logic [6:0]  rr;
    logic        up_tenth;
    logic [4:0]  mi;
    logic        up_int;
    logic [10:0] nr;
    n        = work_q[9:0];
    prod_m   = {6'd0, rem_q} * 16'd41;
    m        = prod_m[15:12];
    rr_w     = rem_q - 10'(m) * 10'd100;
    rr       = rr_w[6:0];
    up_tenth = (rr > 7'd50) || ((rr == 7'd50) && (m[0] || sticky_q));
    mi       = {1'b0, m} + 5'(up_tenth);
    up_int   = (rem_q > 10'd500) || ((rem_q == 10'd500) && (n[0] || sticky_q));
    nr       = {1'b0, n} + 11'(up_int);

    val_d      = n;
    frac_d     = '0;
    has_frac_d = 1'b0;
    has_pfx_d  = 1'b0;
    pfx_d      = prefix_char(level_q);
    if (scaled_q) begin
      has_pfx_d = 1'b1;
      if (n < 10'd10) begin
        if (rem_q >= 10'd950) begin
          // Tenths roll over into the next whole unit.
          val_d      = n + 10'd1;
          has_frac_d = (n != 10'd9);
        end else begin
          has_frac_d = 1'b1;
          frac_d     = (mi == 5'd10) ? 4'd0 : mi[3:0];
        end
      end else if (nr >= 11'(Thousand)) begin
        // Three-digit carry moves to the next prefix as 1.0.
        val_d      = 10'd1;
        has_frac_d = 1'b1;
        pfx_d      = prefix_char(3'(level_q + 3'd1));
      end else begin
        val_d = nr[9:0];
      end
    end
  end

  // Decimal split of the integer part by reciprocal multiplication.
  always_comb begin
    logic [15:0] prod_h;
    logic [9:0]  tw;
    logic [6:0]  t;
    logic [13:0] prod_t;
    logic [6:0]  ow;
    prod_h  = {6'd0, val_q} * 16'd41;
    dig_h_d = prod_h[15:12];
    tw      = val_q - 10'(dig_h_d) * 10'd100;
    t       = tw[6:0];
    prod_t  = {7'd0, t} * 14'd103;
    dig_t_d = prod_t[13:10];
    ow      = t - 7'(dig_t_d) * 7'd10;
    dig_o_d = ow[3:0];
    if (val_q >= 10'd100) begin
      ndig_d = 2'd3;
    end else if (val_q >= 10'd10) begin
      ndig_d = 2'd2;
    end else begin
      ndig_d = 2'd1;
    end
  end

  // Character placement, left aligned, unused positions zero.
  always_comb begin
    logic [7:0] txt [6];
    logic [2:0] pos;
    for (int i = 0; i < 6; i++) begin
      txt[i] = '0;
    end
    pos = '0;
    if (ndig_q == 2'd3) begin
      txt[pos] = AsciiZero | {4'd0, dig_h_q};
      pos      = pos + 3'd1;
    end
    if (ndig_q != 2'd1) begin
      txt[pos] = AsciiZero | {4'd0, dig_t_q};
      pos      = pos + 3'd1;
    end
    txt[pos] = AsciiZero | {4'd0, dig_o_q};
    pos      = pos + 3'd1;
    if (has_frac_q) begin
      txt[pos] = AsciiDot;
      pos      = pos + 3'd1;
      txt[pos] = AsciiZero | {4'd0, frac_q};
      pos      = pos + 3'd1;
    end
    txt[pos] = AsciiSpace;
    pos      = pos + 3'd1;
    if (has_pfx_q) begin
      txt[pos] = pfx_q;
      pos      = pos + 3'd1;
    end
    txt[pos] = AsciiB;
    pos      = pos + 3'd1;
    out_data_d = {5'd0, pos, txt[5], txt[4], txt[3], txt[2], txt[1], txt[0]};
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q   <= count_i;
      rem_q    <= '0;
      sticky_q <= 1'b0;
      level_q  <= '0;
      scaled_q <= 1'b0;
    end
    if (cmd_i.start_div) begin
      // A further division means the previous remainder is a lower group.
      if (scaled_q) begin
        sticky_q <= sticky_q | (rem_q != '0);
        level_q  <= level_q + 3'd1;
      end
      rem_q    <= '0;
      scaled_q <= 1'b1;
    end
    if (cmd_i.div_step) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
    if (cmd_i.round) begin
      val_q      <= val_d;
      frac_q     <= frac_d;
      has_frac_q <= has_frac_d;
      has_pfx_q  <= has_pfx_d;
      pfx_q      <= pfx_d;
    end
    if (cmd_i.digits) begin
      dig_h_q <= dig_h_d;
      dig_t_q <= dig_t_d;
      dig_o_q <= dig_o_d;
      ndig_q  <= ndig_d;
    end
    if (cmd_i.pack) begin
      out_data_q <= out_data_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/byte_count_to_si_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_count_to_si_text
// Renders a 64-bit byte count as short SI text such as "512 B" or "9.8 MB".
// ----------------------------------------------------------------------------
// Each request is one unsigned 64-bit byte count and yields one result of six
// left-aligned ASCII characters (unused ones zero) and the text length. The
// block works on one request at a time. A count below one thousand passes
// through the scan, rounding, digit and packing steps; every division by one
// thousand adds a radix-256 long division, which brings in one byte of the
// count per cycle, and a test of the quotient. The largest counts need six
// divisions. A new request is accepted in the cycle after the result enters
// the output register, which holds it until it is taken.
module byte_count_to_si_text
  import bcsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [63:0] byte_count
  input  logic [CountW-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [7:0] char_0, [15:8] char_1, [23:16] char_2, [31:24] char_3,
  // [39:32] char_4, [47:40] char_5, [50:48] text_length, [55:51] zero
  output logic [ResultW-1:0] m_axis_tdata
);

  bcsi_cmd_t    cmd;
  bcsi_status_t status;

  // Sequencer.
  bcsi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Arithmetic and formatting.
  bcsi_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .count_i       (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
